### src/ssor_pkg.sv
`timescale 1ns / 1ps

package ssor_pkg;

    // Item function codes.
    typedef enum logic [2:0] {
        FN_DIAG      = 3'd0,
        FN_ROW_START = 3'd1,
        FN_SLOT      = 3'd2,
        FN_RHS       = 3'd3,
        FN_RUN       = 3'd4,
        FN_READ      = 3'd5
    } func_t;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORDER      = 2'd0;
    localparam logic [1:0] CFG_RELAXATION = 2'd1;
    localparam logic [1:0] CFG_SWEEPS     = 2'd2;

    // Saturating 32-bit add.
    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    // Saturating 32-bit subtract.
    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

endpackage

### src/sparse_ssor_preconditioner.sv
`timescale 1ns / 1ps

// Sparse SSOR preconditioner. An item is taken when start is high and busy is
// low; its single result appears one cycle with done high and must be taken
// then, since the receiver cannot stall the block. Load items (diagonal, row
// start, off-diagonal slot, right-hand side) and read items are taken one per
// cycle, each result following in the cycle after its item. A run item keeps
// busy high while the solution store is cleared and then through every sweep;
// a slot whose column is not below the effective order is skipped. Each row
// waits on the divider, which gives one quotient bit a cycle, and each store
// has a single read port. After reset, busy stays high while the solution
// store is cleared.
module sparse_ssor_preconditioner #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_SLOTS = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [11:0]        index,
    input  logic [7:0]         column,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_data,
    output logic [1:0]         status,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int N_W     = $clog2(MAX_ROWS + 1);
    localparam int RS_AW   = $clog2(MAX_ROWS + 1);
    localparam int SLOT_AW = $clog2(MAX_SLOTS);
    localparam int RS_W    = $clog2(MAX_SLOTS + 1);
    localparam int DW      = 32 + FRAC_BITS;
    localparam int DCNT_W  = $clog2(DW + 1);
    localparam int PROD_W  = 66;
    localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [PROD_W:0] HALF_Q = (PROD_W + 1)'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        A_RD, A_M1, A_W1, A_M2, A_W2, A_M3, A_W3, A_WR,
        R_RS0, R_RS1, R_RS2,
        B_K, B_KD, B_KX, B_KW, B_KA, B_FW, B_FP, B_DIV,
        D_RD, D_M, D_W, D_P, D_DIV, D_K, D_KD, D_KW, D_KA
    } state_t;

    typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_D} phase_t;

    // Round half up, floor shift and saturate a product.
    function automatic logic signed [31:0] qround(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] r;
        r = {p[PROD_W-1], p} + HALF_Q;
        r = r >>> FRAC_BITS;
        if (r[PROD_W:31] == '0 || r[PROD_W:31] == '1)
            return r[31:0];
        return r[PROD_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    // Configuration registers.
    logic [8:0]  order_reg;
    logic [16:0] relax_reg;
    logic [7:0]  sweeps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= 9'd1;
            relax_reg  <= 17'(1 << FRAC_BITS);
            sweeps_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ssor_pkg::CFG_ORDER:      order_reg  <= cfg_data[8:0];
                ssor_pkg::CFG_RELAXATION: relax_reg  <= cfg_data;
                ssor_pkg::CFG_SWEEPS:     sweeps_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    logic [N_W-1:0] n_eff;
    logic signed [32:0] om, om1;
    assign n_eff = (32'(order_reg) > MAX_ROWS) ? N_W'(MAX_ROWS) : N_W'(order_reg);
    assign om    = $signed({16'b0, relax_reg});
    assign om1   = ONE_Q - om;

    // Control and datapath registers.
    state_t state_reg;
    phase_t ph_reg;
    logic                run_reg, zero_reg, done_reg, rd_ok_reg;
    logic [1:0]          status_reg;
    logic [ROW_W-1:0]    row_reg, j_reg;
    logic [7:0]          step_reg;
    logic [RS_W-1:0]     k_reg, k_end_reg;
    logic signed [31:0]  acc_reg, val_reg, xi_reg, ps_hold_reg;
    logic signed [32:0]  ma_reg, mb_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Store read data.
    logic signed [31:0] diag_rd, rhs_rd, sol_rd, ps_rd, scr_rd;
    logic [RS_W-1:0]    rs_rd;
    logic [39:0]        slot_rd;

    // Divider handshake.
    logic               div_start;
    logic signed [31:0] div_num, div_den;
    logic               div_done_reg, div_zero_reg;
    logic signed [31:0] div_quot_reg;

    logic signed [31:0] q;
    logic [7:0]         slot_col;
    logic signed [31:0] slot_val;
    logic               col_ok, last_row, first_pass, accept;

    assign q          = qround(prod_reg);
    assign slot_col   = slot_rd[39:32];
    assign slot_val   = slot_rd[31:0];
    assign col_ok     = 32'(slot_col) < 32'(n_eff);
    assign last_row   = (32'(row_reg) + 32'd1) == 32'(n_eff);
    assign first_pass = (ph_reg == PH_A) && (step_reg == 8'd0);
    assign accept     = start && (state_reg == S_IDLE);

    // Multiplier: one product per cycle, registered.
    always_ff @(posedge clk)
    begin
        prod_reg <= ma_reg * mb_reg;
    end

    // Store port control.
    logic                 diag_we, rhs_we, rs_we, slot_we, sol_we, ps_we, scr_we;
    logic [ROW_W-1:0]     sol_wa, ps_wa, sol_ra, ps_ra;
    logic signed [31:0]   sol_wd, ps_wd, scr_wd;
    logic [RS_AW-1:0]     rs_ra;

    always_comb
    begin
        diag_we = accept && (func == ssor_pkg::FN_DIAG) && (32'(index) < MAX_ROWS);
        rhs_we  = accept && (func == ssor_pkg::FN_RHS) && (32'(index) < MAX_ROWS);
        rs_we   = accept && (func == ssor_pkg::FN_ROW_START) && (32'(index) <= MAX_ROWS)
                  && !value[31] && (value <= MAX_SLOTS);
        slot_we = accept && (func == ssor_pkg::FN_SLOT) && (32'(index) < MAX_SLOTS);

        sol_we = 1'b0;
        sol_wa = row_reg;
        sol_wd = div_quot_reg;
        ps_we  = 1'b0;
        ps_wa  = row_reg;
        ps_wd  = q;
        scr_we = 1'b0;
        scr_wd = q;
        div_start = 1'b0;
        div_num   = ssor_pkg::qadd(scr_rd, q);
        div_den   = diag_rd;

        case (state_reg)
            S_CLEAR:
            begin
                sol_we = 1'b1;
                sol_wd = '0;
            end
            A_M2:
            begin
                scr_we = first_pass;
            end
            A_WR:
            begin
                scr_we = 1'b1;
                scr_wd = ssor_pkg::qadd(acc_reg, q);
                ps_we  = (ph_reg == PH_C);
                ps_wd  = '0;
            end
            B_FP, D_P:
            begin
                ps_we     = 1'b1;
                div_start = 1'b1;
            end
            B_DIV, D_DIV:
            begin
                sol_we = div_done_reg;
            end
            D_KA:
            begin
                ps_we = 1'b1;
                ps_wa = j_reg;
                ps_wd = ssor_pkg::qsub(ps_hold_reg, q);
            end
            default: ;
        endcase

        sol_ra = row_reg;
        if (state_reg == S_IDLE)
            sol_ra = ROW_W'(index);
        else if (state_reg == B_KD)
            sol_ra = ROW_W'(slot_col);
        ps_ra = (state_reg == D_KD) ? ROW_W'(slot_col) : row_reg;
        rs_ra = (state_reg == R_RS1) ? RS_AW'(row_reg) + RS_AW'(1) : RS_AW'(row_reg);
    end

    ssor_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_diag (
        .clk(clk), .we(diag_we), .wr_addr(ROW_W'(index)), .wr_data(value),
        .rd_addr(row_reg), .rd_data(diag_rd));

    ssor_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_rhs (
        .clk(clk), .we(rhs_we), .wr_addr(ROW_W'(index)), .wr_data(value),
        .rd_addr(row_reg), .rd_data(rhs_rd));

    ssor_ram #(.WIDTH(RS_W), .DEPTH(MAX_ROWS + 1)) u_row_start (
        .clk(clk), .we(rs_we), .wr_addr(RS_AW'(index)), .wr_data(RS_W'(value)),
        .rd_addr(rs_ra), .rd_data(rs_rd));

    ssor_ram #(.WIDTH(40), .DEPTH(MAX_SLOTS)) u_slot (
        .clk(clk), .we(slot_we), .wr_addr(SLOT_AW'(index)), .wr_data({column, value}),
        .rd_addr(k_reg[SLOT_AW-1:0]), .rd_data(slot_rd));

    ssor_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_solution (
        .clk(clk), .we(sol_we), .wr_addr(sol_wa), .wr_data(sol_wd),
        .rd_addr(sol_ra), .rd_data(sol_rd));

    ssor_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_partial (
        .clk(clk), .we(ps_we), .wr_addr(ps_wa), .wr_data(ps_wd),
        .rd_addr(ps_ra), .rd_data(ps_rd));

    ssor_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_scratch (
        .clk(clk), .we(scr_we), .wr_addr(row_reg), .wr_data(scr_wd),
        .rd_addr(row_reg), .rd_data(scr_rd));

    // Divider: restoring, one quotient bit per cycle on magnitudes.
    logic              div_run_reg, div_neg_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [31:0]       rem_reg, dvs_reg;
    logic [DW-1:0]     dvd_reg;
    logic [32:0]       rem_sh;
    logic              rem_ge;
    logic signed [DW:0] div_val;

    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign rem_ge  = rem_sh >= {1'b0, dvs_reg};
    assign div_val = div_neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg  <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (div_start)
            begin
                div_zero_reg <= (div_den == 0);
                div_neg_reg  <= div_num[31] ^ div_den[31];
                rem_reg      <= '0;
                dvs_reg      <= div_den[31] ? 32'(-div_den) : 32'(div_den);
                dvd_reg      <= {(div_num[31] ? 32'(-div_num) : 32'(div_num)),
                                 FRAC_BITS'(0)};
                div_cnt_reg  <= '0;
                if (div_den == 0)
                begin
                    div_quot_reg <= '0;
                    div_done_reg <= 1'b1;
                end
                else
                begin
                    div_run_reg <= 1'b1;
                end
            end
            else if (div_run_reg)
            begin
                if (div_cnt_reg == DCNT_W'(DW))
                begin
                    div_run_reg  <= 1'b0;
                    div_done_reg <= 1'b1;
                    if (div_val[DW:31] == '0 || div_val[DW:31] == '1)
                        div_quot_reg <= div_val[31:0];
                    else
                        div_quot_reg <= div_val[DW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end
                else
                begin
                    rem_reg     <= rem_ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
                    dvd_reg     <= {dvd_reg[DW-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ph_reg     <= PH_A;
            row_reg    <= '0;
            run_reg    <= 1'b0;
            zero_reg   <= 1'b0;
            done_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
            status_reg <= ssor_pkg::ST_OK;
            step_reg   <= '0;
            k_reg      <= '0;
        end
        else
        begin
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (32'(row_reg) == MAX_ROWS - 1)
                    begin
                        row_reg <= '0;
                        if (!run_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else if (n_eff == '0 || sweeps_reg == 8'd0)
                        begin
                            state_reg  <= S_IDLE;
                            run_reg    <= 1'b0;
                            done_reg   <= 1'b1;
                            status_reg <= ssor_pkg::ST_OK;
                        end
                        else
                        begin
                            step_reg  <= '0;
                            ph_reg    <= PH_A;
                            state_reg <= A_RD;
                        end
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ssor_pkg::ST_OK;
                        case (func) inside
                            ssor_pkg::FN_DIAG, ssor_pkg::FN_RHS:
                                if (32'(index) >= MAX_ROWS) status_reg <= ssor_pkg::ST_RANGE;
                            ssor_pkg::FN_ROW_START:
                                if (!(32'(index) <= MAX_ROWS && !value[31]
                                      && value <= MAX_SLOTS))
                                    status_reg <= ssor_pkg::ST_RANGE;
                            ssor_pkg::FN_SLOT:
                                if (32'(index) >= MAX_SLOTS) status_reg <= ssor_pkg::ST_RANGE;
                            ssor_pkg::FN_RUN:
                            begin
                                done_reg  <= 1'b0;
                                run_reg   <= 1'b1;
                                zero_reg  <= 1'b0;
                                row_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            ssor_pkg::FN_READ:
                                if (32'(index) < 32'(n_eff))
                                    rd_ok_reg <= 1'b1;
                                else
                                    status_reg <= ssor_pkg::ST_RANGE;
                            default:
                                status_reg <= ssor_pkg::ST_RANGE;
                        endcase
                    end
                end

                // Relaxation term for one row (first pass: omega times rhs).
                A_RD:
                    state_reg <= A_M1;
                A_M1:
                begin
                    ma_reg    <= first_pass ? om : om1;
                    mb_reg    <= first_pass ? {rhs_rd[31], rhs_rd} : {sol_rd[31], sol_rd};
                    state_reg <= A_W1;
                end
                A_W1:
                    state_reg <= A_M2;
                A_M2:
                begin
                    ma_reg <= {q[31], q};
                    mb_reg <= {diag_rd[31], diag_rd};
                    if (!first_pass)
                        state_reg <= A_W2;
                    else if (last_row)
                    begin
                        row_reg   <= '0;
                        ph_reg    <= PH_B;
                        state_reg <= R_RS0;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= A_RD;
                    end
                end
                A_W2:
                    state_reg <= A_M3;
                A_M3:
                begin
                    acc_reg   <= ssor_pkg::qadd(q, ps_rd);
                    ma_reg    <= om;
                    mb_reg    <= {rhs_rd[31], rhs_rd};
                    state_reg <= A_W3;
                end
                A_W3:
                    state_reg <= A_WR;
                A_WR:
                begin
                    if (!last_row)
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= A_RD;
                    end
                    else if (ph_reg == PH_A)
                    begin
                        row_reg   <= '0;
                        ph_reg    <= PH_B;
                        state_reg <= R_RS0;
                    end
                    else
                    begin
                        row_reg   <= ROW_W'(n_eff - 1'b1);
                        ph_reg    <= PH_D;
                        state_reg <= D_RD;
                    end
                end

                // Fetch the slot range of the current row.
                R_RS0:
                    state_reg <= R_RS1;
                R_RS1:
                begin
                    k_reg     <= rs_rd;
                    state_reg <= R_RS2;
                end
                R_RS2:
                begin
                    k_end_reg <= rs_rd;
                    acc_reg   <= '0;
                    state_reg <= (ph_reg == PH_D) ? D_K : B_K;
                end

                // Forward half-step: gather the sum over the row's slots with in-range columns.
                B_K:
                begin
                    if (k_reg < k_end_reg)
                    begin
                        state_reg <= B_KD;
                    end
                    else
                    begin
                        ma_reg    <= om;
                        mb_reg    <= {acc_reg[31], acc_reg};
                        state_reg <= B_FW;
                    end
                end
                B_KD:
                begin
                    val_reg <= slot_val;
                    if (col_ok)
                    begin
                        state_reg <= B_KX;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= B_K;
                    end
                end
                B_KX:
                begin
                    ma_reg    <= {val_reg[31], val_reg};
                    mb_reg    <= {sol_rd[31], sol_rd};
                    state_reg <= B_KW;
                end
                B_KW:
                    state_reg <= B_KA;
                B_KA:
                begin
                    acc_reg   <= ssor_pkg::qsub(acc_reg, q);
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= B_K;
                end
                B_FW:
                    state_reg <= B_FP;
                B_FP:
                    state_reg <= B_DIV;
                B_DIV:
                begin
                    if (div_done_reg)
                    begin
                        zero_reg <= zero_reg | div_zero_reg;
                        if (last_row)
                        begin
                            row_reg   <= '0;
                            ph_reg    <= PH_C;
                            state_reg <= A_RD;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= R_RS0;
                        end
                    end
                end

                // Backward half-step: solve the row, then scatter into columns.
                D_RD:
                    state_reg <= D_M;
                D_M:
                begin
                    ma_reg    <= om;
                    mb_reg    <= {ps_rd[31], ps_rd};
                    state_reg <= D_W;
                end
                D_W:
                    state_reg <= D_P;
                D_P:
                    state_reg <= D_DIV;
                D_DIV:
                begin
                    if (div_done_reg)
                    begin
                        zero_reg  <= zero_reg | div_zero_reg;
                        xi_reg    <= div_quot_reg;
                        state_reg <= R_RS0;
                    end
                end
                D_K:
                begin
                    if (k_reg < k_end_reg)
                    begin
                        state_reg <= D_KD;
                    end
                    else if (row_reg != '0)
                    begin
                        row_reg   <= row_reg - 1'b1;
                        state_reg <= D_RD;
                    end
                    else if (step_reg + 8'd1 == sweeps_reg)
                    begin
                        state_reg  <= S_IDLE;
                        run_reg    <= 1'b0;
                        done_reg   <= 1'b1;
                        status_reg <= zero_reg ? ssor_pkg::ST_ZERO : ssor_pkg::ST_OK;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        ph_reg    <= PH_A;
                        state_reg <= A_RD;
                    end
                end
                D_KD:
                begin
                    if (col_ok)
                    begin
                        ma_reg    <= {slot_val[31], slot_val};
                        mb_reg    <= {xi_reg[31], xi_reg};
                        j_reg     <= ROW_W'(slot_col);
                        state_reg <= D_KW;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= D_K;
                    end
                end
                D_KW:
                begin
                    ps_hold_reg <= ps_rd;
                    state_reg   <= D_KA;
                end
                D_KA:
                begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= D_K;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign read_data = (done_reg && rd_ok_reg) ? sol_rd : '0;

endmodule

### src/ssor_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ssor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### tb/sv/tb_sparse_ssor_preconditioner.sv
`timescale 1ns / 1ps

module tb_sparse_ssor_preconditioner;

    localparam int ROWS       = 256;
    localparam int SLOTS      = 4096;
    localparam int FRAC       = 16;
    localparam int ONE        = 1 << FRAC;
    localparam int IDLE_LIMIT = 500000;
    localparam int ITEM_BUDGET = 2000;

    // Function codes the block does not define.
    localparam logic [2:0] FN_UNUSED_LO = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI = 3'd7;

    typedef struct {
        logic [2:0]         fn;
        logic [11:0]        idx;
        logic [7:0]         col;
        logic signed [31:0] val;
    } ssor_item_t;

    typedef struct {
        logic signed [31:0] data;
        logic [1:0]         st;
    } ssor_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         func = ssor_pkg::FN_DIAG;
    logic [11:0]        index = '0;
    logic [7:0]         column = '0;
    logic signed [31:0] value = '0;
    logic               done;
    logic signed [31:0] read_data;
    logic [1:0]         status;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = ssor_pkg::CFG_ORDER;
    logic [16:0]        cfg_data = '0;

    sparse_ssor_preconditioner dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .index(index), .column(column), .value(value),
        .done(done), .read_data(read_data), .status(status),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block's matrix, vectors and registers.
    int          diag_mem [ROWS];
    int          rhs_mem  [ROWS];
    int          rs_mem   [ROWS + 1];
    logic [7:0]  col_mem  [SLOTS];
    int          off_mem  [SLOTS];
    int          x_mem    [ROWS];
    int          psum_mem [ROWS];
    int          scr_mem  [ROWS];
    int unsigned cur_order = 1;
    int unsigned cur_omega = ONE;
    int unsigned cur_sweeps = 1;

    ssor_item_t   item_q[$];
    ssor_result_t pending_results[$];
    int           errors = 0;
    int           pushed = 0;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Rounded fixed-point product; the arithmetic shift floors.
    function automatic int fx_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC - 1));
        return sat32(p >>> FRAC);
    endfunction

    function automatic int fx_add(int a, int b);
        return sat32(longint'(a) + longint'(b));
    endfunction

    function automatic int fx_sub(int a, int b);
        return sat32(longint'(a) - longint'(b));
    endfunction

    // Truncating quotient; a zero divisor gives zero and raises the flag.
    function automatic int fx_div(int num, int den, inout bit zero_seen);
        if (den == 0)
        begin
            zero_seen = 1'b1;
            return 0;
        end
        return sat32((longint'(num) * ONE) / longint'(den));
    endfunction

    function automatic int relax_term(longint om1, longint om, int i);
        int t;
        t = fx_mul(fx_mul(om1, x_mem[i]), diag_mem[i]);
        t = fx_add(t, psum_mem[i]);
        return fx_add(t, fx_mul(om, rhs_mem[i]));
    endfunction

    // Full SSOR solve from a zero guess; returns the run status.
    function automatic logic [1:0] ssor_solve();
        int     n;
        longint om;
        longint om1;
        bit     zero_seen;
        int     s;
        int     xi;
        int     j;
        n = (cur_order > ROWS) ? ROWS : cur_order;
        om = cur_omega;
        om1 = longint'(ONE) - om;
        zero_seen = 1'b0;
        for (int i = 0; i < ROWS; i++)
        begin
            x_mem[i] = 0;
            psum_mem[i] = 0;
            scr_mem[i] = 0;
        end
        for (int step = 0; step < cur_sweeps; step++)
        begin
            for (int i = 0; i < n; i++)
                scr_mem[i] = (step == 0) ? fx_mul(om, rhs_mem[i]) : relax_term(om1, om, i);
            // Forward half-step.
            for (int i = 0; i < n; i++)
            begin
                s = 0;
                for (int k = rs_mem[i]; k < rs_mem[i + 1]; k++)
                begin
                    j = col_mem[k];
                    if (j < n)
                        s = fx_sub(s, fx_mul(off_mem[k], x_mem[j]));
                end
                psum_mem[i] = fx_mul(om, s);
                x_mem[i] = fx_div(fx_add(scr_mem[i], psum_mem[i]), diag_mem[i], zero_seen);
            end
            for (int i = 0; i < n; i++)
            begin
                scr_mem[i] = relax_term(om1, om, i);
                psum_mem[i] = 0;
            end
            // Backward half-step scatters each new entry into the rows it couples to.
            for (int i = n - 1; i >= 0; i--)
            begin
                psum_mem[i] = fx_mul(om, psum_mem[i]);
                xi = fx_div(fx_add(scr_mem[i], psum_mem[i]), diag_mem[i], zero_seen);
                x_mem[i] = xi;
                for (int k = rs_mem[i]; k < rs_mem[i + 1]; k++)
                begin
                    j = col_mem[k];
                    if (j < n)
                        psum_mem[j] = fx_sub(psum_mem[j], fx_mul(off_mem[k], xi));
                end
            end
        end
        return zero_seen ? ssor_pkg::ST_ZERO : ssor_pkg::ST_OK;
    endfunction

    function automatic ssor_result_t apply_item(ssor_item_t it);
        ssor_result_t r;
        int           n;
        r.data = '0;
        r.st = ssor_pkg::ST_OK;
        n = (cur_order > ROWS) ? ROWS : cur_order;
        case (it.fn)
            ssor_pkg::FN_DIAG:
                if (it.idx < ROWS) diag_mem[it.idx] = it.val; else r.st = ssor_pkg::ST_RANGE;
            ssor_pkg::FN_ROW_START:
                if (it.idx <= ROWS && it.val >= 0 && it.val <= SLOTS)
                    rs_mem[it.idx] = it.val;
                else
                    r.st = ssor_pkg::ST_RANGE;
            ssor_pkg::FN_SLOT:
                if (it.idx < SLOTS)
                begin
                    col_mem[it.idx] = it.col;
                    off_mem[it.idx] = it.val;
                end
                else
                    r.st = ssor_pkg::ST_RANGE;
            ssor_pkg::FN_RHS:
                if (it.idx < ROWS) rhs_mem[it.idx] = it.val; else r.st = ssor_pkg::ST_RANGE;
            ssor_pkg::FN_RUN:
                r.st = ssor_solve();
            ssor_pkg::FN_READ:
                if (it.idx < n) r.data = x_mem[it.idx]; else r.st = ssor_pkg::ST_RANGE;
            default:
                r.st = ssor_pkg::ST_RANGE;
        endcase
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Sender: bursts of random length separated by random gaps.
    ssor_item_t cur;
    int         burst_left = 4;
    int         gap_left = 0;
    bit         calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                pending_results.push_back(apply_item(cur));
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    cur = item_q.pop_front();
                    func <= cur.fn;
                    index <= cur.idx;
                    column <= cur.col;
                    value <= cur.val;
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 7) == 0)
                            calm = !calm;
                        gap_left = calm ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result checker and activity watchdog.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        ssor_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    report("unexpected result status", status, -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (read_data !== want.data)
                        report("read_data", read_data, want.data);
                    if (status !== want.st)
                        report("status", status, want.st);
                end
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic add_item(logic [2:0] fn, int idx, int col, int val);
        ssor_item_t it;
        it.fn = fn;
        it.idx = 12'(idx);
        it.col = 8'(col);
        it.val = val;
        item_q.push_back(it);
        pushed++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (item_q.size() > 0 || start || pending_results.size() > 0 || busy);
        repeat (4) @(negedge clk);
    endtask

    // Registers are written back to back, then the write enable drops.
    task automatic set_config(int unsigned ord, int unsigned om, int unsigned sw);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= ssor_pkg::CFG_ORDER;
        cfg_data <= 17'(ord);
        @(posedge clk);
        cfg_index <= ssor_pkg::CFG_RELAXATION;
        cfg_data <= 17'(om);
        @(posedge clk);
        cfg_index <= ssor_pkg::CFG_SWEEPS;
        cfg_data <= 17'(sw);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_order = ord & 9'h1ff;
        cur_omega = om & 17'h1ffff;
        cur_sweeps = sw & 8'hff;
    endtask

    function automatic int rand_signed(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    // Loads a whole system of n rows, runs it, and reads every entry back.
    task automatic build_system(int n, bit all_zero_diag);
        int base;
        int cursor;
        int cnt;
        int d;
        base = $urandom_range(0, SLOTS - 4 * n - 1);
        cursor = base;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: d = 0;
                1: d = $urandom;
                default: d = int'($urandom_range(2 * ONE, 6 * ONE)) * ($urandom_range(0, 3) == 0 ? -1 : 1);
            endcase
            add_item(ssor_pkg::FN_DIAG, i, $urandom_range(0, 255), all_zero_diag ? 0 : d);
            add_item(ssor_pkg::FN_RHS, i, $urandom_range(0, 255),
                     ($urandom_range(0, 19) == 0) ? int'($urandom) : rand_signed(4 * ONE));
        end
        add_item(ssor_pkg::FN_ROW_START, 0, 0, base);
        for (int i = 0; i < n; i++)
        begin
            if (cursor > base && $urandom_range(0, 15) == 0)
            begin
                // Reversed bound: this row has no slots.
                add_item(ssor_pkg::FN_ROW_START, i + 1, 0, cursor - 1);
                continue;
            end
            cnt = $urandom_range(0, 3);
            for (int k = 0; k < cnt; k++)
                add_item(ssor_pkg::FN_SLOT, cursor + k,
                         ($urandom_range(0, 9) == 0 || i == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, i - 1),
                         ($urandom_range(0, 29) == 0) ? int'($urandom) : rand_signed(ONE / 2));
            cursor += cnt;
            add_item(ssor_pkg::FN_ROW_START, i + 1, 0, cursor);
        end
        add_item(ssor_pkg::FN_RUN, $urandom_range(0, 4095), $urandom_range(0, 255), $urandom);
        for (int i = 0; i < n; i++)
            add_item(ssor_pkg::FN_READ, i, 0, 0);
        add_item(ssor_pkg::FN_READ, $urandom_range(n, 4095), $urandom_range(0, 255), $urandom);
    endtask

    // Random items that never start a run.
    task automatic add_noise(int count);
        logic [2:0] fn;
        for (int k = 0; k < count; k++)
        begin
            fn = 3'($urandom_range(0, 7));
            if (fn == ssor_pkg::FN_RUN)
                fn = ssor_pkg::FN_READ;
            add_item(fn, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300),
                     $urandom_range(0, 255), $urandom);
        end
    endtask

    initial
    begin
        int ord;
        int om;
        int sw;
        int phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, range errors, undefined codes and a zero diagonal.
        add_item(ssor_pkg::FN_DIAG, ROWS - 1, 8'hff, 32'sh8000_0000);
        add_item(ssor_pkg::FN_RHS, ROWS - 1, 0, 32'sh7fff_ffff);
        add_item(ssor_pkg::FN_DIAG, 4095, 0, 0);
        add_item(ssor_pkg::FN_RHS, ROWS, 0, 0);
        add_item(ssor_pkg::FN_SLOT, SLOTS - 1, 8'hff, 32'sh7fff_ffff);
        add_item(ssor_pkg::FN_SLOT, 4095 + 0, 0, 0);
        add_item(ssor_pkg::FN_ROW_START, ROWS + 1, 0, 0);
        add_item(ssor_pkg::FN_ROW_START, 0, 0, -1);
        add_item(ssor_pkg::FN_ROW_START, 0, 0, SLOTS + 1);
        add_item(ssor_pkg::FN_ROW_START, ROWS, 0, SLOTS);
        add_item(FN_UNUSED_LO, 0, 0, 0);
        add_item(FN_UNUSED_HI, 4095, 8'hff, -1);
        add_item(ssor_pkg::FN_READ, 0, 0, 0);
        build_system(1, 1'b1);
        wait_idle();

        // Phases with fresh register settings, extremes first.
        phase = 0;
        while (pushed < ITEM_BUDGET)
        begin
            case (phase)
                0: begin ord = ROWS; om = ONE;        sw = 1;   end
                1: begin ord = 2;    om = 1;          sw = 255; end
                2: begin ord = 3;    om = 131071;     sw = 2;   end
                3: begin ord = 1;    om = ONE;        sw = 0;   end
                default:
                begin
                    ord = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
                    om = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 131071)
                                                      : $urandom_range(ONE / 2, ONE * 19 / 10);
                    sw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
                end
            endcase
            set_config(ord, om, sw);
            build_system(ord, 1'b0);
            add_noise($urandom_range(2, 10));
            if (ord < 64 && $urandom_range(0, 1) == 0)
                build_system(ord, 1'b0);
            wait_idle();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (pending_results.size() > 0)
            report("results never seen", 0, pending_results.size());
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
